/* hw/rtl/crot_pkg.sv */
`timescale 1ns / 1ps

package crot_pkg;

    // Pairing of the two shape kinds; selects which overlap rule applies.
    typedef enum logic [1:0] {
        PAIR_RECT_RECT = 2'd0,
        PAIR_CIRC_RECT = 2'd1,
        PAIR_CIRC_CIRC = 2'd2
    } t_pair_kind;

    // Shape kind codes as carried on the request user bits.
    localparam logic SHAPE_RECT   = 1'b0;
    localparam logic SHAPE_CIRCLE = 1'b1;

endpackage

/* hw/rtl/crot_front.sv */
`timescale 1ns / 1ps

// Center deltas, box limits and squarer operands for one shape pair.
module crot_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                     i_left_is_circle,
    input  logic [COORD_BITS-1:0]    i_left_x,
    input  logic [COORD_BITS-1:0]    i_left_y,
    input  logic [COORD_BITS-2:0]    i_left_w,
    input  logic [COORD_BITS-2:0]    i_left_h,
    input  logic                     i_right_is_circle,
    input  logic [COORD_BITS-1:0]    i_right_x,
    input  logic [COORD_BITS-1:0]    i_right_y,
    input  logic [COORD_BITS-2:0]    i_right_w,
    input  logic [COORD_BITS-2:0]    i_right_h,
    output crot_pkg::t_pair_kind     o_kind,
    output logic [COORD_BITS+1:0]    o_ax2,
    output logic [COORD_BITS+1:0]    o_ay2,
    output logic [COORD_BITS-1:0]    o_lim_x0,
    output logic [COORD_BITS-1:0]    o_lim_y0,
    output logic [COORD_BITS-1:0]    o_lim_x1,
    output logic [COORD_BITS-1:0]    o_lim_y1,
    output logic [COORD_BITS+1:0]    o_sq_a,
    output logic [COORD_BITS+1:0]    o_sq_b,
    output logic [COORD_BITS-1:0]    o_sq_ref
);
    import crot_pkg::*;

    localparam int N = COORD_BITS;

    logic [N:0]   dx;
    logic [N:0]   dy;
    logic [N:0]   adx;
    logic [N:0]   ady;
    logic [N-2:0] c_w;
    logic [N-2:0] r_w;
    logic [N-2:0] r_h;
    logic [N-1:0] sum_w;
    logic [N-1:0] sum_h;
    logic [N-1:0] rw_cw;
    logic [N-1:0] rh_cw;
    logic [N+2:0] ex;
    logic [N+2:0] ey;
    logic [N+2:0] aex;
    logic [N+2:0] aey;

    // Signed center differences, one bit wider than a coordinate
    assign dx  = {i_left_x[N-1], i_left_x} - {i_right_x[N-1], i_right_x};
    assign dy  = {i_left_y[N-1], i_left_y} - {i_right_y[N-1], i_right_y};
    assign adx = dx[N] ? (~dx + 1'b1) : dx;
    assign ady = dy[N] ? (~dy + 1'b1) : dy;

    // Doubled absolute deltas
    assign o_ax2 = {adx, 1'b0};
    assign o_ay2 = {ady, 1'b0};

    // Pick circle and rectangle sides for the mixed case
    assign c_w = i_left_is_circle ? i_left_w  : i_right_w;
    assign r_w = i_left_is_circle ? i_right_w : i_left_w;
    assign r_h = i_left_is_circle ? i_right_h : i_left_h;

    assign sum_w = {1'b0, i_left_w} + {1'b0, i_right_w};
    assign sum_h = {1'b0, i_left_h} + {1'b0, i_right_h};
    assign rw_cw = {1'b0, r_w} + {1'b0, c_w};
    assign rh_cw = {1'b0, r_h} + {1'b0, c_w};

    // Doubled offset of the circle center from the nearest rectangle corner
    assign ex  = {1'b0, o_ax2} - {4'b0000, r_w};
    assign ey  = {1'b0, o_ay2} - {4'b0000, r_h};
    assign aex = ex[N+2] ? (~ex + 1'b1) : ex;
    assign aey = ey[N+2] ? (~ey + 1'b1) : ey;

    always_comb begin
        if (i_left_is_circle == SHAPE_CIRCLE && i_right_is_circle == SHAPE_CIRCLE) begin
            o_kind = PAIR_CIRC_CIRC;
        end else if (i_left_is_circle == SHAPE_CIRCLE
                     || i_right_is_circle == SHAPE_CIRCLE) begin
            o_kind = PAIR_CIRC_RECT;
        end else begin
            o_kind = PAIR_RECT_RECT;
        end
    end

    always_comb begin
        o_lim_x0 = sum_w;
        o_lim_y0 = sum_h;
        o_lim_x1 = sum_w;
        o_lim_y1 = sum_h;
        o_sq_a   = o_ax2;
        o_sq_b   = o_ay2;
        o_sq_ref = sum_w;
        if (o_kind == PAIR_CIRC_RECT) begin
            o_lim_x0 = rw_cw;
            o_lim_y0 = {1'b0, r_h};
            o_lim_x1 = {1'b0, r_w};
            o_lim_y1 = rh_cw;
            o_sq_a   = aex[N+1:0];
            o_sq_b   = aey[N+1:0];
            o_sq_ref = {1'b0, c_w};
        end
    end

endmodule

/* hw/rtl/crot_decide.sv */
`timescale 1ns / 1ps

// Squared-distance compare and box tests, merged by pair kind.
module crot_decide #(
    parameter int COORD_BITS = 16
) (
    input  crot_pkg::t_pair_kind     i_kind,
    input  logic [COORD_BITS+1:0]    i_ax2,
    input  logic [COORD_BITS+1:0]    i_ay2,
    input  logic [COORD_BITS-1:0]    i_lim_x0,
    input  logic [COORD_BITS-1:0]    i_lim_y0,
    input  logic [COORD_BITS-1:0]    i_lim_x1,
    input  logic [COORD_BITS-1:0]    i_lim_y1,
    input  logic [COORD_BITS+1:0]    i_sq_a,
    input  logic [COORD_BITS+1:0]    i_sq_b,
    input  logic [COORD_BITS-1:0]    i_sq_ref,
    output logic                     o_hit
);
    import crot_pkg::*;

    localparam int N = COORD_BITS;

    logic [2*N+3:0] sq_a2;
    logic [2*N+3:0] sq_b2;
    logic [2*N+4:0] dist2;
    logic [2*N-1:0] ref2;
    logic           near;
    logic           box0;
    logic           box1;

    assign sq_a2 = i_sq_a * i_sq_a;
    assign sq_b2 = i_sq_b * i_sq_b;
    assign ref2  = i_sq_ref * i_sq_ref;
    assign dist2 = {1'b0, sq_a2} + {1'b0, sq_b2};
    assign near  = dist2 < {5'b00000, ref2};

    assign box0 = (i_ax2 <= {2'b00, i_lim_x0}) && (i_ay2 <= {2'b00, i_lim_y0});
    assign box1 = (i_ax2 <= {2'b00, i_lim_x1}) && (i_ay2 <= {2'b00, i_lim_y1});

    always_comb begin
        case (i_kind)
            PAIR_CIRC_CIRC: o_hit = near;
            PAIR_CIRC_RECT: o_hit = box0 || box1 || near;
            PAIR_RECT_RECT: o_hit = box0;
            default:        o_hit = 1'b0;
        endcase
    end

endmodule

/* hw/rtl/circle_rect_overlap_test_unit.sv */
`timescale 1ns / 1ps
// Hit valid rises on the master side once a request has passed the input
// register and then the result register. Throughput: one shape pair per cycle
// unless m_axis_tready stalls the master side; the three squarers in crot_decide are
// used once per request between the input register and the result register.
// Reset (i_rst_n low, synchronous) drops both valid flags; data registers
// keep whatever they held and are reloaded with the next request.
module circle_rect_overlap_test_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // left_x, left_y, left_w, left_h, right_x, right_y, right_w, right_h, zero pad
    input  logic [((8*COORD_BITS-4+7)/8)*8-1:0] s_axis_tdata,
    // left_is_circle, right_is_circle
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit, zero pad
    output logic [7:0]                    m_axis_tdata
);
    import crot_pkg::*;

    localparam int N      = COORD_BITS;
    localparam int DATA_W = ((8*N-4+7)/8)*8;
    localparam int OUT_W  = 8;

    // Field offsets within s_axis_tdata, lowest field first
    localparam int LX_LO = 0;
    localparam int LY_LO = LX_LO + N;
    localparam int LW_LO = LY_LO + N;
    localparam int LH_LO = LW_LO + N - 1;
    localparam int RX_LO = LH_LO + N - 1;
    localparam int RY_LO = RX_LO + N;
    localparam int RW_LO = RY_LO + N;
    localparam int RH_LO = RW_LO + N - 1;

    localparam int USER_LEFT  = 0;
    localparam int USER_RIGHT = 1;

    // Input register stage
    logic              r_in_valid;
    logic              n_in_valid;
    logic [DATA_W-1:0] r_in_data;
    logic [1:0]        r_in_user;

    // Result register stage
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_out_hit;

    logic              stage_ready;
    logic              in_take;
    logic              out_load;

    t_pair_kind        kind;
    logic [N+1:0]      ax2;
    logic [N+1:0]      ay2;
    logic [N-1:0]      lim_x0;
    logic [N-1:0]      lim_y0;
    logic [N-1:0]      lim_x1;
    logic [N-1:0]      lim_y1;
    logic [N+1:0]      sq_a;
    logic [N+1:0]      sq_b;
    logic [N-1:0]      sq_ref;
    logic              hit;

    // The result register frees up when empty or when its request is taken;
    // the input register frees up when empty or when it moves forward.
    assign stage_ready   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || stage_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_load      = r_in_valid && stage_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
        n_out_valid = r_out_valid;
        if (stage_ready) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= s_axis_tdata;
            r_in_user <= s_axis_tuser;
        end
    end

    // Capture the verdict when the input stage advances
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit <= hit;
        end
    end

    crot_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_left_is_circle  (r_in_user[USER_LEFT]),
        .i_left_x          (r_in_data[LX_LO +: N]),
        .i_left_y          (r_in_data[LY_LO +: N]),
        .i_left_w          (r_in_data[LW_LO +: N-1]),
        .i_left_h          (r_in_data[LH_LO +: N-1]),
        .i_right_is_circle (r_in_user[USER_RIGHT]),
        .i_right_x         (r_in_data[RX_LO +: N]),
        .i_right_y         (r_in_data[RY_LO +: N]),
        .i_right_w         (r_in_data[RW_LO +: N-1]),
        .i_right_h         (r_in_data[RH_LO +: N-1]),
        .o_kind            (kind),
        .o_ax2             (ax2),
        .o_ay2             (ay2),
        .o_lim_x0          (lim_x0),
        .o_lim_y0          (lim_y0),
        .o_lim_x1          (lim_x1),
        .o_lim_y1          (lim_y1),
        .o_sq_a            (sq_a),
        .o_sq_b            (sq_b),
        .o_sq_ref          (sq_ref)
    );

    crot_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .i_kind    (kind),
        .i_ax2     (ax2),
        .i_ay2     (ay2),
        .i_lim_x0  (lim_x0),
        .i_lim_y0  (lim_y0),
        .i_lim_x1  (lim_x1),
        .i_lim_y1  (lim_y1),
        .i_sq_a    (sq_a),
        .i_sq_b    (sq_b),
        .i_sq_ref  (sq_ref),
        .o_hit     (hit)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, r_out_hit};

    // A request leaving the input stage must show up as a result
    a_advance_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("request advanced but result register is empty");

    // Never stall the slave side while the result register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("slave side stalled with empty result register");

    // A blocked input stage keeps its request
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !stage_ready) |=> (r_in_valid && $stable(r_in_data)
                                          && $stable(r_in_user)))
        else $error("input stage lost a blocked request");

    // Two circles never overlap when their diameters sum to zero
    a_zero_circles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && kind == PAIR_CIRC_CIRC && sq_ref == '0) |=> !r_out_hit)
        else $error("zero-size circles reported as overlapping");

endmodule
